@@ sv/rlc_pkg.sv @@
// Shared types and constants for the raster line compositor.
package rlc_pkg;

    // Defaults for the top-level parameters.
    localparam int LINE_PIXELS_DEF  = 384;
    localparam int SPRITE_COUNT_DEF = 8;

    // Fixed geometry of the character area.
    localparam int CHAR_COLUMNS = 40;
    localparam int CHAR_W       = 25;
    localparam int CHAR_X0      = 24;

    // Raster x of the line center, and the width of raster x arithmetic.
    localparam int RASTER_CENTER = 184;
    localparam int RX_W          = 11;

    // Border window edges for the forty- and thirty-eight-column modes.
    localparam int WIN_L_WIDE   = 24;
    localparam int WIN_R_WIDE   = 344;
    localparam int WIN_L_NARROW = 31;
    localparam int WIN_R_NARROW = 335;

    // Sprite widths in pixels, normal and double.
    localparam int SPRITE_SPAN     = 24;
    localparam int SPRITE_SPAN_DBL = 48;

    // Input operation codes.
    typedef enum logic [1:0] {
        OP_HEADER = 2'd0,
        OP_CHAR   = 2'd1,
        OP_SPRITE = 2'd2,
        OP_EMIT   = 2'd3
    } t_op;

    // Line header as held between headers.
    typedef struct packed {
        logic [3:0] c3;
        logic [3:0] c1;
        logic [3:0] bcol;
        logic       wide;
        logic [2:0] xscroll;
        logic       border_on;
    } t_header;

    // One stored sprite: position and the meaningful word bits.
    typedef struct packed {
        logic [8:0]  x;
        logic [30:0] word;
    } t_sprite;

endpackage

@@ sv/raster_line_compositor.sv @@
// Top level of the raster line compositor: stores, sequencer and output register.
//
// Header, character and sprite transactions are each stored on their handshake. An emit
// streams the line out as ceil(LINE_PIXELS/8) groups of eight pixels. The shared
// pixel unit resolves one pixel per cycle behind a two-step pipeline whose first
// step is the registered read of the character RAM, so each group passes through
// the issue state, a drain state and a state that loads the output register, and
// waits in that last state while the output side stalls. The input is not ready for
// the length of an emit. The output register lets a finished group wait while the
// next one is being built.
module raster_line_compositor import rlc_pkg::*; #(
    parameter int LINE_PIXELS  = LINE_PIXELS_DEF,
    parameter int SPRITE_COUNT = SPRITE_COUNT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_operation,
    input  logic [5:0]  i_slot,
    input  logic [31:0] i_word,
    input  logic [8:0]  i_sprite_x,
    input  logic        i_border_on,
    input  logic [2:0]  i_xscroll,
    input  logic        i_wide_columns,
    input  logic [3:0]  i_border_color,
    input  logic [3:0]  i_sprite_color_one,
    input  logic [3:0]  i_sprite_color_two,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [5:0]  o_group,
    output logic [3:0]  o_pixel_a,
    output logic [3:0]  o_pixel_b,
    output logic [3:0]  o_pixel_c,
    output logic [3:0]  o_pixel_d,
    output logic [3:0]  o_pixel_e,
    output logic [3:0]  o_pixel_f,
    output logic [3:0]  o_pixel_g,
    output logic [3:0]  o_pixel_h,
    output logic        o_last
);

    localparam int GROUPS  = (LINE_PIXELS + 7) / 8;
    localparam int SIDX_W  = (SPRITE_COUNT > 1) ? $clog2(SPRITE_COUNT) : 1;
    localparam int CADDR_W = $clog2(CHAR_COLUMNS);
    localparam logic signed [RX_W-1:0] RX_OFF = RX_W'(RASTER_CENTER - LINE_PIXELS / 2);
    localparam logic [5:0] LAST_GROUP = 6'(GROUPS - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DRAIN,
        S_PUSH
    } t_state;

    t_state  r_state;
    t_header r_header;
    t_sprite r_sprite [SPRITE_COUNT];
    logic [CHAR_COLUMNS-1:0] r_char_valid;

    logic [5:0] r_group;
    logic [2:0] r_k;

    logic                   r_s1_valid;
    logic signed [RX_W-1:0] r_s1_rx;
    logic [2:0]             r_s1_q;
    logic                   r_s1_chit;
    logic                   r_s1_inline;
    logic [2:0]             r_s1_k;
    logic                   r_s1_cvalid;

    logic [3:0] r_asm [8];
    logic       r_out_valid;
    logic [5:0] r_out_group;
    logic [3:0] r_out_pix [8];
    logic       r_out_last;

    logic                   in_xact;
    logic                   out_xact;
    logic                   out_free;
    logic [8:0]             pix_idx;
    logic signed [RX_W-1:0] rx;
    logic signed [RX_W-1:0] pos;
    logic                   char_hit;
    logic [CADDR_W-1:0]     char_addr;
    logic                   char_we;
    logic [CHAR_W-1:0]      char_rdata;
    logic [CHAR_W-1:0]      char_word;
    logic [3:0]             pixel;

    assign in_xact  = i_in_valid && o_in_ready;
    assign out_xact = r_out_valid && i_out_ready;
    assign out_free = !r_out_valid || i_out_ready;

    // Line header, sprite and character-valid registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header <= '0;
            for (int s = 0; s < SPRITE_COUNT; s++) begin
                r_sprite[s] <= '0;
            end
            r_char_valid <= '0;
        end else if (in_xact) begin
            unique case (t_op'(i_operation))
                OP_HEADER: begin
                    r_header.border_on <= i_border_on;
                    r_header.xscroll   <= i_xscroll;
                    r_header.wide      <= i_wide_columns;
                    r_header.bcol      <= i_border_color;
                    r_header.c1        <= i_sprite_color_one;
                    r_header.c3        <= i_sprite_color_two;
                end
                OP_CHAR: begin
                    if (char_we) begin
                        r_char_valid[i_slot[CADDR_W-1:0]] <= 1'b1;
                    end
                end
                OP_SPRITE: begin
                    if ({26'd0, i_slot} < SPRITE_COUNT) begin
                        r_sprite[i_slot[SIDX_W-1:0]].word <= i_word[30:0];
                        r_sprite[i_slot[SIDX_W-1:0]].x    <= i_sprite_x;
                    end
                end
                OP_EMIT: begin
                end
                default: begin
                end
            endcase
        end
    end

    // Character store.
    assign char_we = in_xact && (t_op'(i_operation) == OP_CHAR) &&
                     ({26'd0, i_slot} < CHAR_COLUMNS);

    rlc_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (CHAR_COLUMNS)
    ) u_char_ram (
        .i_clk   (i_clk),
        .i_we    (char_we),
        .i_waddr (i_slot[CADDR_W-1:0]),
        .i_wdata ({i_word[31], i_word[23:0]}),
        .i_raddr (char_addr),
        .o_rdata (char_rdata)
    );

    // Issue step: raster position of the current pixel and its character column.
    assign pix_idx   = {r_group, r_k};
    assign rx        = $signed({2'b00, pix_idx}) + RX_OFF;
    assign pos       = rx - RX_W'(CHAR_X0) - $signed({8'd0, r_header.xscroll});
    assign char_hit  = (pos >= 0) && (pos < RX_W'(8 * CHAR_COLUMNS));
    assign char_addr = char_hit ? pos[CADDR_W+2:3] : '0;

    // Pipeline register between issue and the pixel unit.
    always_ff @(posedge i_clk) begin
        r_s1_rx     <= rx;
        r_s1_q      <= pos[2:0];
        r_s1_chit   <= char_hit;
        r_s1_inline <= ({1'b0, pix_idx} < 10'(LINE_PIXELS));
        r_s1_k      <= r_k;
        r_s1_cvalid <= r_char_valid[char_addr];
    end

    // A column never written reads as all zero.
    assign char_word = r_s1_cvalid ? char_rdata : '0;

    rlc_pixel_unit #(
        .SPRITE_COUNT (SPRITE_COUNT)
    ) u_pixel (
        .i_rx        (r_s1_rx),
        .i_q         (r_s1_q),
        .i_char_hit  (r_s1_chit),
        .i_in_line   (r_s1_inline),
        .i_char_word (char_word),
        .i_header    (r_header),
        .i_sprites   (r_sprite),
        .o_pixel     (pixel)
    );

    // Group assembly.
    always_ff @(posedge i_clk) begin
        if (r_s1_valid) begin
            r_asm[r_s1_k] <= pixel;
        end
    end

    // Sequencer and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_group     <= '0;
            r_k         <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid <= (r_state == S_RUN);
            // The register empties on a taken group unless a new one loads in the same cycle.
            if (out_xact && !((r_state == S_PUSH) && out_free)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_xact && (t_op'(i_operation) == OP_EMIT)) begin
                        r_group <= '0;
                        r_k     <= '0;
                        r_state <= S_RUN;
                    end
                end
                S_RUN: begin
                    r_k <= r_k + 3'd1;
                    if (r_k == 3'd7) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    r_state <= S_PUSH;
                end
                S_PUSH: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_group <= r_group;
                        r_out_last  <= (r_group == LAST_GROUP);
                        r_out_pix   <= r_asm;
                        if (r_group == LAST_GROUP) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_group <= r_group + 6'd1;
                            r_state <= S_RUN;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_group     = r_out_group;
    assign o_last      = r_out_last;
    assign o_pixel_a   = r_out_pix[0];
    assign o_pixel_b   = r_out_pix[1];
    assign o_pixel_c   = r_out_pix[2];
    assign o_pixel_d   = r_out_pix[3];
    assign o_pixel_e   = r_out_pix[4];
    assign o_pixel_f   = r_out_pix[5];
    assign o_pixel_g   = r_out_pix[6];
    assign o_pixel_h   = r_out_pix[7];

endmodule

@@ sv/rlc_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
module rlc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/rlc_pixel_unit.sv @@
// Shared pixel unit: resolves border, sprite and character priority for one pixel.
module rlc_pixel_unit import rlc_pkg::*; #(
    parameter int SPRITE_COUNT = SPRITE_COUNT_DEF
) (
    input  logic signed [RX_W-1:0] i_rx,
    input  logic [2:0]             i_q,
    input  logic                   i_char_hit,
    input  logic                   i_in_line,
    input  logic [CHAR_W-1:0]      i_char_word,
    input  t_header                i_header,
    input  t_sprite                i_sprites [SPRITE_COUNT],
    output logic [3:0]             o_pixel
);

    logic signed [RX_W-1:0]  win_left;
    logic signed [RX_W-1:0]  win_right;
    logic                    in_border;
    logic [SPRITE_COUNT-1:0] spr_hit;
    logic [3:0]              spr_col [SPRITE_COUNT];
    logic                    sp_hit;
    logic [3:0]              sp_col;
    logic [1:0]              char_pair;
    logic [1:0]              char_code;
    logic [3:0]              char_col;

    // Border window test.
    assign win_left  = i_header.wide ? RX_W'(WIN_L_WIDE)  : RX_W'(WIN_L_NARROW);
    assign win_right = i_header.wide ? RX_W'(WIN_R_WIDE)  : RX_W'(WIN_R_NARROW);
    assign in_border = i_header.border_on || (i_rx < win_left) || (i_rx >= win_right);

    // Per-sprite coverage and colour.
    for (genvar s = 0; s < SPRITE_COUNT; s++) begin : g_spr
        logic [31:0]            w;
        logic signed [RX_W-1:0] off;
        logic                   in_span;
        logic [4:0]             spr_px;
        logic [3:0]             pair;
        logic [1:0]             code;
        logic                   bit_on;

        assign w       = {1'b0, i_sprites[s].word};
        assign off     = i_rx - $signed({2'b00, i_sprites[s].x});
        assign in_span = (off >= 0) &&
                         (off < (w[30] ? RX_W'(SPRITE_SPAN_DBL) : RX_W'(SPRITE_SPAN)));
        assign spr_px  = w[30] ? off[5:1] : off[4:0];
        assign pair    = spr_px[4:1];
        assign code    = w[5'd22 - {pair, 1'b0} +: 2];
        assign bit_on  = w[5'd23 - spr_px];

        assign spr_hit[s] = (w != 32'd0) && in_span && (w[29] ? (code != 2'd0) : bit_on);

        always_comb begin
            if (!w[29]) begin
                spr_col[s] = w[27:24];
            end else begin
                case (code)
                    2'd1:    spr_col[s] = i_header.c1;
                    2'd2:    spr_col[s] = w[27:24];
                    default: spr_col[s] = i_header.c3;
                endcase
            end
        end
    end

    // Higher sprite numbers override lower ones.
    always_comb begin
        sp_hit = 1'b0;
        sp_col = 4'd0;
        for (int s = 0; s < SPRITE_COUNT; s++) begin
            if (spr_hit[s]) begin
                sp_hit = 1'b1;
                sp_col = spr_col[s];
            end
        end
    end

    // Character pixel, hires or multicolour.
    assign char_pair = i_q[2:1];
    assign char_code = i_char_word[3'd7 - {char_pair, 1'b0} -: 2];

    always_comb begin
        if (!i_char_hit) begin
            char_col = 4'd0;
        end else if (i_char_word[24]) begin
            char_col = i_char_word[5'd8 + {1'b0, char_code, 2'b00} +: 4];
        end else if (i_char_word[3'd7 - i_q]) begin
            char_col = i_char_word[15:12];
        end else begin
            char_col = i_char_word[11:8];
        end
    end

    // Final priority.
    always_comb begin
        if (!i_in_line) begin
            o_pixel = 4'd0;
        end else if (in_border) begin
            o_pixel = i_header.bcol;
        end else if (sp_hit) begin
            o_pixel = sp_col;
        end else begin
            o_pixel = char_col;
        end
    end

endmodule

@@ sv/rlc_checker.sv @@
// Port-level assertions for the raster line compositor, bound to the top level.
module rlc_checker import rlc_pkg::*; #(
    parameter int LINE_PIXELS = LINE_PIXELS_DEF
) (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_ready,
    input logic [1:0] i_operation,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [5:0] o_group,
    input logic [3:0] o_pixel_a,
    input logic       o_last
);

    localparam logic [5:0] LAST_GROUP = 6'((LINE_PIXELS + 7) / 8 - 1);

    // A stalled output transaction holds its group, first pixel and last flag.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_group) && $stable(o_pixel_a) && $stable(o_last)))
        else $error("output payload changed while stalled");

    // The last flag marks exactly the final group of the line.
    a_last_group: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_last == (o_group == LAST_GROUP)))
        else $error("last flag does not match the final group");

    // An emit makes the input busy on the next cycle.
    a_emit_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && (i_operation == OP_EMIT)) |=> !o_in_ready)
        else $error("input ready right after an emit");

    // Groups of a line come out in order.
    a_group_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && !o_last) |=>
            (!o_out_valid || (o_group == $past(o_group) + 6'd1)))
        else $error("group index out of sequence");

endmodule

bind raster_line_compositor rlc_checker #(.LINE_PIXELS(LINE_PIXELS)) u_rlc_checker (.*);
